FILE: sv/sec_pkg.sv
// shared types and constants for the spectrum envelope checker
`default_nettype none

package sec_pkg;

  // payload and register widths
  localparam int VALUE_W   = 32;
  localparam int ERR_W     = 19;
  localparam int NEG_W     = 17;
  localparam int COUNT_W   = 11;
  localparam int NEG_THR_W = 16;
  localparam int POS_THR_W = 19;
  localparam int LIMIT_W   = 11;
  localparam int CFG_W     = 19;
  localparam int CFG_IDX_W = 2;

  // quotient bits produced by the divider, one per step
  localparam int DIV_STEPS = ERR_W;
  localparam int STEP_W    = $clog2(DIV_STEPS);

  localparam int MAX_POINTS_DEF = 1024;

  localparam logic [ERR_W-1:0] POS_SAT = {ERR_W{1'b1}};

  // register reset values
  localparam logic [NEG_THR_W-1:0] NEG_THR_RST     = 16'd6554;
  localparam logic [POS_THR_W-1:0] POS_THR_RST     = 19'd19661;
  localparam logic [LIMIT_W-1:0]   BELOW_LIMIT_RST = 11'd5;
  localparam logic [LIMIT_W-1:0]   ABOVE_LIMIT_RST = 11'd5;

  // register indexes
  localparam logic [CFG_IDX_W-1:0] CFG_NEG_THRESHOLD = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_POS_THRESHOLD = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_BELOW_LIMIT   = 2'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_ABOVE_LIMIT   = 2'd3;

  // controller to datapath
  typedef struct packed {
    logic load_in;
    logic prep;
    logic mul;
    logic div_step;
    logic update;
    logic emit;
  } sec_cmd_t;

  // datapath to controller
  typedef struct packed {
    logic last;
  } sec_sts_t;

endpackage

`default_nettype wire

FILE: sv/sec_ctrl.sv
// sequencing state machine and result handshake for the envelope checker
`default_nettype none

module sec_ctrl
  import sec_pkg::*;
(
  input  wire logic     clk,
  input  wire logic     rst_n,
  input  wire logic     in_valid,
  output logic          in_ready,
  output logic          out_valid,
  input  wire logic     out_ready,
  input  wire sec_sts_t sts,
  output sec_cmd_t      cmd
);

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_PREP,
    ST_MUL,
    ST_DIV,
    ST_UPDATE,
    ST_EMIT
  } state_t;

  state_t            state_r, state_nxt;
  logic [STEP_W-1:0] step_r, step_nxt;
  logic              out_valid_r, out_valid_nxt;

  always_comb begin
    state_nxt = state_r;
    step_nxt  = step_r;
    cmd       = '0;
    case (state_r)
      ST_IDLE: begin
        if (in_valid) begin
          cmd.load_in = 1'b1;
          state_nxt   = ST_PREP;
        end
      end
      ST_PREP: begin
        cmd.prep  = 1'b1;
        state_nxt = ST_MUL;
      end
      ST_MUL: begin
        cmd.mul   = 1'b1;
        step_nxt  = STEP_W'(DIV_STEPS - 1);
        state_nxt = ST_DIV;
      end
      ST_DIV: begin
        cmd.div_step = 1'b1;
        if (step_r == '0) begin
          state_nxt = ST_UPDATE;
        end else begin
          step_nxt = step_r - 1'b1;
        end
      end
      ST_UPDATE: begin
        cmd.update = 1'b1;
        state_nxt  = sts.last ? ST_EMIT : ST_IDLE;
      end
      ST_EMIT: begin
        // wait for the output slot to free up
        if (!out_valid_r || out_ready) begin
          cmd.emit  = 1'b1;
          state_nxt = ST_IDLE;
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  always_comb begin
    if (cmd.emit) begin
      out_valid_nxt = 1'b1;
    end else if (out_ready) begin
      out_valid_nxt = 1'b0;
    end else begin
      out_valid_nxt = out_valid_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      step_r      <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      step_r      <= step_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  assign in_ready  = (state_r == ST_IDLE);
  assign out_valid = out_valid_r;

`ifndef ASSERT_OFF
  a_emit_slot_free: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.emit |-> (!out_valid_r || out_ready))
    else $error("result loaded over a pending result");

  a_emit_sets_valid: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.emit |=> out_valid_r)
    else $error("result loaded without valid");

  a_accept_starts: assert property (@(posedge clk) disable iff (!rst_n)
    (in_valid && in_ready) |=> (state_r == ST_PREP))
    else $error("accepted request did not start processing");

  a_div_ends: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_DIV && step_r == '0) |=> (state_r == ST_UPDATE))
    else $error("divider did not finish after its last step");

  a_busy_no_ready: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_DIV) |-> !in_ready)
    else $error("input ready while dividing");
`endif

endmodule

`default_nettype wire

FILE: sv/sec_dp.sv
// datapath: error magnitude divider, threshold compares, extremes and counts
`default_nettype none

module sec_dp
  import sec_pkg::*;
#(
  parameter int MAX_POINTS = MAX_POINTS_DEF
) (
  input  wire logic                 clk,
  input  wire logic                 rst_n,
  input  wire sec_cmd_t             cmd,
  output sec_sts_t                  sts,
  input  wire logic                 cfg_we,
  input  wire logic [CFG_IDX_W-1:0] cfg_index,
  input  wire logic [CFG_W-1:0]     cfg_wdata,
  input  wire logic [VALUE_W-1:0]   in_calc_value,
  input  wire logic [VALUE_W-1:0]   in_target_value,
  input  wire logic                 in_last_point,
  output logic [ERR_W-1:0]          out_max_abs_error,
  output logic [ERR_W-1:0]          out_max_positive_error,
  output logic signed [NEG_W-1:0]   out_max_negative_error,
  output logic [COUNT_W-1:0]        out_deep_below_count,
  output logic [COUNT_W-1:0]        out_below_count,
  output logic [COUNT_W-1:0]        out_far_above_count,
  output logic                      out_pass
);

  localparam int CNT_W  = $clog2(MAX_POINTS + 1);
  localparam int CMP_W  = (CNT_W > LIMIT_W) ? CNT_W : LIMIT_W;
  localparam int NUM_W  = VALUE_W + 16;
  localparam int PROD_W = VALUE_W + POS_THR_W;

  // configuration
  logic [NEG_THR_W-1:0] neg_thr_r;
  logic [POS_THR_W-1:0] pos_thr_r;
  logic [LIMIT_W-1:0]   below_limit_r;
  logic [LIMIT_W-1:0]   above_limit_r;

  // current point
  logic [VALUE_W-1:0] calc_r, target_r;
  logic               last_r;
  logic [VALUE_W-1:0] diff_r, diff_nxt;
  logic               below_r, above_r;
  logic               sat_r;
  logic [PROD_W-1:0]  prod_r;
  logic [VALUE_W-1:0] rem_r, rem_nxt;
  logic [ERR_W-1:0]   dvd_r;
  logic [ERR_W-1:0]   quo_r;

  // running state
  logic [ERR_W-1:0] largest_r, largest_nxt;
  logic [NEG_W-1:0] neg_mag_r, neg_mag_nxt;
  logic [CNT_W-1:0] below_cnt_r, below_cnt_nxt;
  logic [CNT_W-1:0] deep_cnt_r, deep_cnt_nxt;
  logic [CNT_W-1:0] far_cnt_r, far_cnt_nxt;

  logic [POS_THR_W-1:0] thr_sel;
  logic [VALUE_W:0]     trial;
  logic                 trial_ge;
  logic [NUM_W-1:0]     num;
  logic                 over_thr;
  logic [ERR_W-1:0]     pos_err;
  logic [ERR_W-1:0]     neg_mag_ext;
  logic                 pass_now;

  function automatic logic [CNT_W-1:0] bump(input logic [CNT_W-1:0] c);
    bump = (c < CNT_W'(MAX_POINTS)) ? c + 1'b1 : c;
  endfunction

  // configuration writes
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      neg_thr_r     <= NEG_THR_RST;
      pos_thr_r     <= POS_THR_RST;
      below_limit_r <= BELOW_LIMIT_RST;
      above_limit_r <= ABOVE_LIMIT_RST;
    end else if (cfg_we) begin
      case (cfg_index)
        CFG_NEG_THRESHOLD: neg_thr_r     <= cfg_wdata[NEG_THR_W-1:0];
        CFG_POS_THRESHOLD: pos_thr_r     <= cfg_wdata[POS_THR_W-1:0];
        CFG_BELOW_LIMIT:   below_limit_r <= cfg_wdata[LIMIT_W-1:0];
        CFG_ABOVE_LIMIT:   above_limit_r <= cfg_wdata[LIMIT_W-1:0];
        default: begin
        end
      endcase
    end
  end

  // input capture and prep
  always_comb begin
    diff_nxt = (calc_r < target_r) ? (target_r - calc_r) : (calc_r - target_r);
  end

  always_ff @(posedge clk) begin
    if (cmd.load_in) begin
      calc_r   <= in_calc_value;
      target_r <= in_target_value;
      last_r   <= in_last_point;
    end
    if (cmd.prep) begin
      diff_r  <= diff_nxt;
      below_r <= (calc_r < target_r);
      above_r <= (calc_r > target_r);
    end
  end

  // threshold product and divider setup, then one quotient bit per step
  assign thr_sel  = below_r ? POS_THR_W'(neg_thr_r) : pos_thr_r;
  assign trial    = {rem_r, dvd_r[ERR_W-1]};
  assign trial_ge = (trial >= {1'b0, target_r});

  always_comb begin
    rem_nxt = trial_ge ? VALUE_W'(trial - {1'b0, target_r}) : trial[VALUE_W-1:0];
  end

  always_ff @(posedge clk) begin
    if (cmd.mul) begin
      prod_r <= PROD_W'(thr_sel) * PROD_W'(target_r);
      // quotient would not fit in 19 bits (also covers a zero target)
      sat_r  <= ({3'b000, diff_r} >= {target_r, 3'b000});
      rem_r  <= VALUE_W'(diff_r >> 3);
      dvd_r  <= {diff_r[2:0], 16'h0000};
      quo_r  <= '0;
    end else if (cmd.div_step) begin
      rem_r <= rem_nxt;
      dvd_r <= {dvd_r[ERR_W-2:0], 1'b0};
      quo_r <= {quo_r[ERR_W-2:0], trial_ge};
    end
  end

  // accumulate
  assign num         = {diff_r, 16'h0000};
  assign over_thr    = (PROD_W'(num) > prod_r);
  assign pos_err     = sat_r ? POS_SAT : quo_r;
  assign neg_mag_ext = ERR_W'(neg_mag_r);

  always_comb begin
    largest_nxt   = largest_r;
    neg_mag_nxt   = neg_mag_r;
    below_cnt_nxt = below_cnt_r;
    deep_cnt_nxt  = deep_cnt_r;
    far_cnt_nxt   = far_cnt_r;
    if (cmd.update) begin
      if (below_r) begin
        below_cnt_nxt = bump(below_cnt_r);
        if (over_thr) begin
          deep_cnt_nxt = bump(deep_cnt_r);
        end
        if (quo_r > neg_mag_ext) begin
          neg_mag_nxt = quo_r[NEG_W-1:0];
        end
      end else if (above_r) begin
        if (over_thr) begin
          far_cnt_nxt = bump(far_cnt_r);
        end
        if (pos_err > largest_r) begin
          largest_nxt = pos_err;
        end
      end
    end else if (cmd.emit) begin
      largest_nxt   = '0;
      neg_mag_nxt   = '0;
      below_cnt_nxt = '0;
      deep_cnt_nxt  = '0;
      far_cnt_nxt   = '0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      largest_r   <= '0;
      neg_mag_r   <= '0;
      below_cnt_r <= '0;
      deep_cnt_r  <= '0;
      far_cnt_r   <= '0;
    end else begin
      largest_r   <= largest_nxt;
      neg_mag_r   <= neg_mag_nxt;
      below_cnt_r <= below_cnt_nxt;
      deep_cnt_r  <= deep_cnt_nxt;
      far_cnt_r   <= far_cnt_nxt;
    end
  end

  // result register
  assign pass_now = (deep_cnt_r == '0)
                 && (CMP_W'(below_cnt_r) <= CMP_W'(below_limit_r))
                 && (CMP_W'(far_cnt_r) <= CMP_W'(above_limit_r));

  always_ff @(posedge clk) begin
    if (cmd.emit) begin
      out_max_abs_error      <= (largest_r > neg_mag_ext) ? largest_r : neg_mag_ext;
      out_max_positive_error <= largest_r;
      out_max_negative_error <= NEG_W'(-neg_mag_r);
      out_deep_below_count   <= COUNT_W'(deep_cnt_r);
      out_below_count        <= COUNT_W'(below_cnt_r);
      out_far_above_count    <= COUNT_W'(far_cnt_r);
      out_pass               <= pass_now;
    end
  end

  assign sts.last = last_r;

endmodule

`default_nettype wire

FILE: sv/spectrum_envelope_checker.sv
// top level of the spectrum envelope checker
`default_nettype none

// Checks a computed spectrum against a target one point per request, forming the
// relative error (calc - target) / target in saturating Q3.16 with a 19-step
// restoring divider. Each point passes through capture, difference, threshold
// multiply and divider setup, 19 divider steps and an update before the next
// point can be accepted. The point marked last then loads the result register,
// waiting first while an earlier result has not yet been taken. The result
// register lets the next spectrum start while the last result is still pending.
// Registers are written through cfg_we/cfg_index/cfg_wdata; the user must write
// them only while the block is idle, as the block itself does not enforce this.

module spectrum_envelope_checker
  import sec_pkg::*;
#(
  parameter int MAX_POINTS = MAX_POINTS_DEF
) (
  input  wire logic                 clk,
  input  wire logic                 rst_n,
  input  wire logic                 cfg_we,
  input  wire logic [CFG_IDX_W-1:0] cfg_index,
  input  wire logic [CFG_W-1:0]     cfg_wdata,
  input  wire logic                 in_valid,
  output logic                      in_ready,
  input  wire logic [VALUE_W-1:0]   in_calc_value,
  input  wire logic [VALUE_W-1:0]   in_target_value,
  input  wire logic                 in_last_point,
  output logic                      out_valid,
  input  wire logic                 out_ready,
  output logic [ERR_W-1:0]          out_max_abs_error,
  output logic [ERR_W-1:0]          out_max_positive_error,
  output logic signed [NEG_W-1:0]   out_max_negative_error,
  output logic [COUNT_W-1:0]        out_deep_below_count,
  output logic [COUNT_W-1:0]        out_below_count,
  output logic [COUNT_W-1:0]        out_far_above_count,
  output logic                      out_pass
);

  sec_cmd_t cmd;
  sec_sts_t sts;

  sec_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .sts       (sts),
    .cmd       (cmd)
  );

  sec_dp #(
    .MAX_POINTS (MAX_POINTS)
  ) u_dp (
    .clk                    (clk),
    .rst_n                  (rst_n),
    .cmd                    (cmd),
    .sts                    (sts),
    .cfg_we                 (cfg_we),
    .cfg_index              (cfg_index),
    .cfg_wdata              (cfg_wdata),
    .in_calc_value          (in_calc_value),
    .in_target_value        (in_target_value),
    .in_last_point          (in_last_point),
    .out_max_abs_error      (out_max_abs_error),
    .out_max_positive_error (out_max_positive_error),
    .out_max_negative_error (out_max_negative_error),
    .out_deep_below_count   (out_deep_below_count),
    .out_below_count        (out_below_count),
    .out_far_above_count    (out_far_above_count),
    .out_pass               (out_pass)
  );

endmodule

`default_nettype wire
